[hw/rtl/scd_pkg.sv]
`default_nettype none

package scd_pkg;

    // Fixed field widths
    localparam int PHASE_W     = 24;
    localparam int STEP_W      = 16;
    localparam int DLY_CFG_W   = 19;
    localparam int GAIN_W      = 16;
    localparam int FRAC_W      = 8;
    localparam int CFG_DATA_W  = 19;
    localparam int CFG_IDX_W   = 3;
    localparam int GAIN_SHIFT  = 15;
    localparam int SHAPE_SHIFT = 23;
    localparam int ROUND_HALF  = 1 << (GAIN_SHIFT - 1);

    // Parameter defaults
    localparam int DEF_LINE_DEPTH  = 2048;
    localparam int DEF_SAMPLE_BITS = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DELAY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WET_GAIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRY_GAIN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd5;

    // Register reset values
    localparam logic [STEP_W-1:0]           RST_PHASE_STEP    = 16'd50;
    localparam logic [DLY_CFG_W-1:0]        RST_MOD_DEPTH     = 19'd94658;
    localparam logic [DLY_CFG_W-1:0]        RST_MIN_DELAY     = 19'd0;
    localparam logic [GAIN_W-1:0]           RST_WET_GAIN      = 16'd15401;
    localparam logic [GAIN_W-1:0]           RST_DRY_GAIN      = 16'd17367;
    localparam logic signed [GAIN_W-1:0]    RST_FEEDBACK_GAIN = -16'sd12452;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_SHAPE,
        ST_DLY,
        ST_READ,
        ST_INTERP,
        ST_TAP,
        ST_OUT
    } scd_state_t;

    typedef struct packed {
        logic advance;
        logic wr_en;
        logic rd_en;
    } scd_line_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/scd_delay_line.sv]
`default_nettype none

module scd_delay_line
    import scd_pkg::*;
#(
    parameter int LINE_DEPTH  = DEF_LINE_DEPTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire scd_line_ctl_t                      ctl,
    input  wire logic [2*SAMPLE_BITS-1:0]           wr_data,
    input  wire logic [$clog2(LINE_DEPTH)-1:0]      rd_offset,
    output logic      [2*SAMPLE_BITS-1:0]           rd_t0,
    output logic      [2*SAMPLE_BITS-1:0]           rd_t1
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int DW = 2 * SAMPLE_BITS;
    localparam logic [AW-1:0] LAST_POS  = AW'(LINE_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_CNT = (AW + 1)'(LINE_DEPTH);

    // Both channels share one row: left in the low half, right in the high half
    logic [DW-1:0] mem [LINE_DEPTH];

    logic [AW-1:0] wp_reg, wp_next;
    logic [AW:0]   fill_reg, fill_next;
    logic [AW:0]   addr_sum;
    logic [AW-1:0] addr0, addr1, off1;
    logic          valid0, valid1;
    logic          v0_reg, v1_reg;
    logic [DW-1:0] q0_reg, q1_reg;

    always_comb begin
        wp_next = wp_reg;
        if (ctl.advance) begin
            wp_next = (wp_reg == '0) ? LAST_POS : wp_reg - AW'(1);
        end
        fill_next = fill_reg;
        if (ctl.wr_en && fill_reg != DEPTH_CNT) begin
            fill_next = fill_reg + (AW + 1)'(1);
        end
    end

    // Taps sit at offset and offset+1 above the write position, modulo the depth
    always_comb begin
        addr_sum = {1'b0, wp_reg} + {1'b0, rd_offset};
        if (addr_sum >= DEPTH_CNT) begin
            addr0 = AW'(addr_sum - DEPTH_CNT);
        end else begin
            addr0 = addr_sum[AW-1:0];
        end
        addr1 = (addr0 == LAST_POS) ? '0 : addr0 + AW'(1);
        off1  = (rd_offset == LAST_POS) ? '0 : rd_offset + AW'(1);
        // Entries written since reset form a run of fill_reg rows from the write position up
        valid0 = {1'b0, rd_offset} < fill_reg;
        valid1 = {1'b0, off1} < fill_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            fill_reg <= '0;
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
        end else begin
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
            if (ctl.rd_en) begin
                v0_reg <= valid0;
                v1_reg <= valid1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wp_reg] <= wr_data;
        end
        if (ctl.rd_en) begin
            q0_reg <= mem[addr0];
            q1_reg <= mem[addr1];
        end
    end

    // Rows never written read as zero
    assign rd_t0 = v0_reg ? q0_reg : '0;
    assign rd_t1 = v1_reg ? q1_reg : '0;

endmodule

`default_nettype wire

[hw/rtl/stereo_chorus_delay.sv]
`default_nettype none

// Stereo modulated-delay chorus. Each accepted beat carries one left/right sample pair and
// gives one output pair. Both channels are written into a shared ring of LINE_DEPTH rows
// (plus feedback of the previous tap), read back at a delay swept by a squared phase
// accumulator, linearly interpolated and mixed as dry*in - wet*tap with rounding and
// saturation. From acceptance until its result is loaded, an item runs through the chain
// of dependent steps phase square, depth product, delay clamp, ring read, interpolation
// product, wet product and final mix; no new beat is taken until the item has been loaded
// and the block is back in idle. A result still waiting on m_tready holds the next item at
// its final step. The ring is one memory with one write and two
// read ports; a fill count masks rows not yet written, so no clearing pass follows reset.
// Configuration writes are taken at any edge with cfg_we high but are meant for idle
// periods; writing feedback_gain also clears the phase.
module stereo_chorus_delay
    import scd_pkg::*;
#(
    parameter int LINE_DEPTH  = DEF_LINE_DEPTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                                       aclk,
    input  wire logic                                       aresetn,
    input  wire logic                                       s_tvalid,
    output logic                                            s_tready,
    // left_sample, right_sample
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]         s_tdata,
    output logic                                            m_tvalid,
    input  wire logic                                       m_tready,
    // left_out, right_out
    output logic      [((2*SAMPLE_BITS+7)/8)*8-1:0]         m_tdata,
    input  wire logic                                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]                       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]                      cfg_wdata
);

    localparam int SW      = SAMPLE_BITS;
    localparam int AW      = $clog2(LINE_DEPTH);
    localparam int TDATA_W = ((2 * SW + 7) / 8) * 8;
    localparam int DP_W    = DLY_CFG_W + PHASE_W;
    localparam int DLY_W   = (AW + FRAC_W > DP_W - SHAPE_SHIFT) ? AW + FRAC_W
                                                                : DP_W - SHAPE_SHIFT;
    localparam logic [DLY_W-1:0] DMAX = DLY_W'(LINE_DEPTH * 256 - 1);
    localparam logic [2*PHASE_W-1:0] SHAPE_ONE = (2 * PHASE_W)'(1) << (2 * SHAPE_SHIFT);

    function automatic logic signed [SW-1:0] sat_s(input logic signed [SW+3:0] x);
        if (&x[SW+3:SW-1] || ~|x[SW+3:SW-1]) begin
            return x[SW-1:0];
        end else if (x[SW+3]) begin
            return {1'b1, {(SW - 1){1'b0}}};
        end else begin
            return {1'b0, {(SW - 1){1'b1}}};
        end
    endfunction

    // Configuration
    logic [STEP_W-1:0]           phase_step_reg;
    logic [DLY_CFG_W-1:0]        mod_depth_reg;
    logic [DLY_CFG_W-1:0]        min_delay_reg;
    logic [GAIN_W-1:0]           wet_gain_reg;
    logic [GAIN_W-1:0]           dry_gain_reg;
    logic signed [GAIN_W-1:0]    fb_gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg <= RST_PHASE_STEP;
            mod_depth_reg  <= RST_MOD_DEPTH;
            min_delay_reg  <= RST_MIN_DELAY;
            wet_gain_reg   <= RST_WET_GAIN;
            dry_gain_reg   <= RST_DRY_GAIN;
            fb_gain_reg    <= RST_FEEDBACK_GAIN;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PHASE_STEP:    phase_step_reg <= cfg_wdata[STEP_W-1:0];
                REG_MOD_DEPTH:     mod_depth_reg  <= cfg_wdata[DLY_CFG_W-1:0];
                REG_MIN_DELAY:     min_delay_reg  <= cfg_wdata[DLY_CFG_W-1:0];
                REG_WET_GAIN:      wet_gain_reg   <= cfg_wdata[GAIN_W-1:0];
                REG_DRY_GAIN:      dry_gain_reg   <= cfg_wdata[GAIN_W-1:0];
                REG_FEEDBACK_GAIN: fb_gain_reg    <= $signed(cfg_wdata[GAIN_W-1:0]);
                default: ;
            endcase
        end
    end

    // Sequencer
    scd_state_t    state_reg, state_next;
    scd_line_ctl_t line_ctl;
    logic          accept;
    logic          out_free;
    logic          out_load;
    logic          m_valid_reg;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        s_tready         = 1'b0;
        out_load         = 1'b0;
        line_ctl.advance = 1'b0;
        line_ctl.wr_en   = 1'b0;
        line_ctl.rd_en   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    line_ctl.advance = 1'b1;
                    state_next       = ST_SQ;
                end
            end
            ST_SQ:     state_next = ST_SHAPE;
            ST_SHAPE: begin
                line_ctl.wr_en = 1'b1;
                state_next     = ST_DLY;
            end
            ST_DLY:    state_next = ST_READ;
            ST_READ: begin
                line_ctl.rd_en = 1'b1;
                state_next     = ST_INTERP;
            end
            ST_INTERP: state_next = ST_TAP;
            ST_TAP:    state_next = ST_OUT;
            ST_OUT: begin
                // hold here until the output register frees up
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Phase and delay
    logic [PHASE_W-1:0]      phase_reg;
    logic [2*PHASE_W-1:0]    sq_reg;
    logic signed [2*PHASE_W-1:0] sq_next;
    logic [2*PHASE_W-1:0]    shape_full;
    logic [PHASE_W-1:0]      shape;
    logic [DP_W-1:0]         dprod_reg;
    logic [DLY_W-1:0]        d_sum;
    logic [DLY_W-1:0]        d_reg;
    logic [AW-1:0]           rd_offset;
    logic [FRAC_W-1:0]       frac;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else if (cfg_we && cfg_index == REG_FEEDBACK_GAIN) begin
            phase_reg <= '0;
        end else if (accept) begin
            phase_reg <= phase_reg + PHASE_W'(phase_step_reg);
        end
    end

    // Wrapping from +1 to -1 leaves the square unchanged
    assign sq_next    = $signed(phase_reg) * $signed(phase_reg);
    assign shape_full = SHAPE_ONE - sq_reg;
    assign shape      = shape_full[2*SHAPE_SHIFT:SHAPE_SHIFT];
    assign d_sum      = DLY_W'(min_delay_reg) + DLY_W'(dprod_reg[DP_W-1:SHAPE_SHIFT]);
    assign rd_offset  = d_reg[AW+FRAC_W-1:FRAC_W];
    assign frac       = d_reg[FRAC_W-1:0];

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SQ) begin
            sq_reg <= sq_next;
        end
        if (state_reg == ST_SHAPE) begin
            dprod_reg <= mod_depth_reg * shape;
        end
        if (state_reg == ST_DLY) begin
            d_reg <= (d_sum > DMAX) ? DMAX : d_sum;
        end
    end

    // Channel lanes: 0 left, 1 right
    logic [SW-1:0]      wr_lane  [2];
    logic [SW-1:0]      out_lane [2];
    logic [2*SW-1:0]    line_wr;
    logic [2*SW-1:0]    line_t0;
    logic [2*SW-1:0]    line_t1;
    logic [2*SW-1:0]    m_data_reg;

    assign line_wr = {wr_lane[1], wr_lane[0]};

    for (genvar c = 0; c < 2; c++) begin : g_lane
        logic signed [SW-1:0]   in_reg;
        logic signed [SW-1:0]   tap_reg;
        logic signed [SW+15:0]  fb_prod_reg;
        logic signed [SW+16:0]  dry_prod_reg;
        logic signed [SW+16:0]  wet_prod_reg;
        logic signed [SW-1:0]   t0_reg;
        logic signed [SW+9:0]   ip_reg;
        logic signed [SW-1:0]   rd0;
        logic signed [SW-1:0]   rd1;
        logic signed [SW:0]     tdiff;
        logic signed [SW+9:0]   ip_next;
        logic [SW+16:0]         fb_rnd_sum;
        logic signed [SW+3:0]   line_sum;
        logic signed [SW+1:0]   tap_sum;
        logic signed [SW-1:0]   tap_next;
        logic signed [SW+16:0]  wet_next;
        logic [SW+17:0]         out_diff;
        logic [SW+17:0]         out_rnd;

        assign rd0 = line_t0[c*SW +: SW];
        assign rd1 = line_t1[c*SW +: SW];

        // Line write: input plus rounded feedback of the previous tap
        assign fb_rnd_sum = {fb_prod_reg[SW+15], fb_prod_reg} + (SW + 17)'(ROUND_HALF);
        assign line_sum   = $signed({{4{in_reg[SW-1]}}, in_reg})
                          + $signed({{2{fb_rnd_sum[SW+16]}}, fb_rnd_sum[SW+16:GAIN_SHIFT]});
        assign wr_lane[c] = sat_s(line_sum);

        // Interpolate between the two taps
        assign tdiff    = {rd1[SW-1], rd1} - {rd0[SW-1], rd0};
        assign ip_next  = tdiff * $signed({1'b0, frac});
        assign tap_sum  = {{2{t0_reg[SW-1]}}, t0_reg} + ip_reg[SW+9:FRAC_W];
        assign tap_next = tap_sum[SW-1:0];
        assign wet_next = $signed({1'b0, wet_gain_reg}) * tap_next;

        // Mix, round half up, saturate
        assign out_diff    = {dry_prod_reg[SW+16], dry_prod_reg}
                           - {wet_prod_reg[SW+16], wet_prod_reg};
        assign out_rnd     = out_diff + (SW + 18)'(ROUND_HALF);
        assign out_lane[c] = sat_s({out_rnd[SW+17], out_rnd[SW+17:GAIN_SHIFT]});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tap_reg <= '0;
            end else if (state_reg == ST_TAP) begin
                tap_reg <= tap_next;
            end
        end

        always_ff @(posedge aclk) begin
            if (accept) begin
                in_reg <= s_tdata[c*SW +: SW];
            end
            if (state_reg == ST_SQ) begin
                fb_prod_reg  <= fb_gain_reg * tap_reg;
                dry_prod_reg <= $signed({1'b0, dry_gain_reg}) * in_reg;
            end
            if (state_reg == ST_INTERP) begin
                t0_reg <= rd0;
                ip_reg <= ip_next;
            end
            if (state_reg == ST_TAP) begin
                wet_prod_reg <= wet_next;
            end
        end
    end

    scd_delay_line #(
        .LINE_DEPTH  (LINE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_line (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (line_ctl),
        .wr_data   (line_wr),
        .rd_offset (rd_offset),
        .rd_t0     (line_t0),
        .rd_t1     (line_t1)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {out_lane[1], out_lane[0]};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'(m_data_reg);

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second beat taken while an item is in flight");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the final step");

    a_delay_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> (d_reg <= DMAX))
        else $error("delay beyond ring length at read");
`endif

endmodule

`default_nettype wire

[test/scd_checker.sv]
`default_nettype none

module scd_checker
    import scd_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    input  wire logic                    s_tready,
    input  wire logic [31:0]             s_tdata,
    input  wire logic                    m_tvalid,
    input  wire logic                    m_tready,
    input  wire logic [31:0]             m_tdata,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_wdata,
    output int                           fail_count,
    output int                           outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     LINE_DEPTH  = DEF_LINE_DEPTH;
    localparam int     SAMPLE_BITS = DEF_SAMPLE_BITS;
    localparam int     POS_W       = $clog2(LINE_DEPTH);
    localparam longint DELAY_MAX   = longint'(LINE_DEPTH) * (1 << FRAC_W) - 1;

    // left sits in the low half of the beat
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] right;
        logic signed [SAMPLE_BITS-1:0] left;
    } stereo_pair_t;

    logic [STEP_W-1:0]             step_reg;
    logic [DLY_CFG_W-1:0]          depth_reg;
    logic [DLY_CFG_W-1:0]          offset_reg;
    logic [GAIN_W-1:0]             wet_reg;
    logic [GAIN_W-1:0]             dry_reg;
    logic signed [GAIN_W-1:0]      fb_reg;

    logic signed [SAMPLE_BITS-1:0] ring [2][LINE_DEPTH];
    longint                        tap [2];
    logic [POS_W-1:0]              wr_pos;
    logic [PHASE_W-1:0]            phase;

    stereo_pair_t                  expected_q [$];
    int                            out_beats;

    function automatic longint clamp_sample(input longint x);
        longint hi;
        longint lo;
        hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction

    function automatic longint round_q15(input longint x);
        return (x + ROUND_HALF) >>> GAIN_SHIFT;
    endfunction

    // Advance phase and write pointer, then run both channels through the ring.
    function automatic stereo_pair_t mix_chorus(input stereo_pair_t x);
        longint       dry_in [2];
        longint       wet_out [2];
        longint       ph;
        longint       shape;
        longint       dly;
        longint       t0;
        longint       t1;
        longint       tv;
        int unsigned  whole;
        int unsigned  frac;
        int unsigned  i0;
        int unsigned  i1;
        int           ch;
        stereo_pair_t y;
        dry_in[0] = x.left;
        dry_in[1] = x.right;
        phase = phase + step_reg;
        ph = longint'(signed'(phase));
        wr_pos = wr_pos - 1'b1;
        shape = ((longint'(1) << (2 * SHAPE_SHIFT)) - ph * ph) >>> SHAPE_SHIFT;
        dly = longint'(offset_reg) + ((longint'(depth_reg) * shape) >>> SHAPE_SHIFT);
        if (dly > DELAY_MAX) dly = DELAY_MAX;
        whole = int'(dly >> FRAC_W);
        frac = int'(dly & ((1 << FRAC_W) - 1));
        for (ch = 0; ch < 2; ch++) begin
            // write first, so a zero delay taps the fresh entry
            ring[ch][wr_pos] = clamp_sample(dry_in[ch] + round_q15(longint'(fb_reg) * tap[ch]));
            i0 = (wr_pos + whole) % LINE_DEPTH;
            i1 = (i0 + 1) % LINE_DEPTH;
            t0 = ring[ch][i0];
            t1 = ring[ch][i1];
            tv = t0 + ((longint'(frac) * (t1 - t0)) >>> FRAC_W);
            tap[ch] = tv;
            wet_out[ch] = clamp_sample(round_q15(longint'(dry_reg) * dry_in[ch]
                                                 - longint'(wet_reg) * tv));
        end
        y.left = wet_out[0];
        y.right = wet_out[1];
        return y;
    endfunction

    initial begin
        fail_count = 0;
        outstanding = 0;
        out_beats = 0;
    end

    always @(posedge aclk) begin
        stereo_pair_t want;
        stereo_pair_t got;
        if (!aresetn) begin
            step_reg = RST_PHASE_STEP;
            depth_reg = RST_MOD_DEPTH;
            offset_reg = RST_MIN_DELAY;
            wet_reg = RST_WET_GAIN;
            dry_reg = RST_DRY_GAIN;
            fb_reg = RST_FEEDBACK_GAIN;
            for (int i = 0; i < LINE_DEPTH; i++) begin
                ring[0][i] = '0;
                ring[1][i] = '0;
            end
            tap[0] = 0;
            tap[1] = 0;
            wr_pos = '0;
            phase = '0;
            expected_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = stereo_pair_t'(m_tdata);
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("output beat %0d with nothing expected: left %0d right %0d",
                                 out_beats, got.left, got.right);
                end else begin
                    want = expected_q.pop_front();
                    if (got.left !== want.left || got.right !== want.right) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("output beat %0d: left exp %0d got %0d, right exp %0d got %0d",
                                     out_beats, want.left, got.left, want.right, got.right);
                    end
                end
                out_beats++;
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_PHASE_STEP:    step_reg = cfg_wdata[STEP_W-1:0];
                    REG_MOD_DEPTH:     depth_reg = cfg_wdata[DLY_CFG_W-1:0];
                    REG_MIN_DELAY:     offset_reg = cfg_wdata[DLY_CFG_W-1:0];
                    REG_WET_GAIN:      wet_reg = cfg_wdata[GAIN_W-1:0];
                    REG_DRY_GAIN:      dry_reg = cfg_wdata[GAIN_W-1:0];
                    REG_FEEDBACK_GAIN: begin
                        fb_reg = cfg_wdata[GAIN_W-1:0];
                        phase = '0;
                    end
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(mix_chorus(stereo_pair_t'(s_tdata)));
        end
        outstanding = expected_q.size();
    end

endmodule

`default_nettype wire

[test/tb.sv]
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scd_pkg::*;

    localparam int SAMPLE_BITS    = DEF_SAMPLE_BITS;
    localparam int PAIR_W         = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int ITEM_TARGET    = 1400;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int QUIET_LIMIT    = 3000;
    localparam int DELAY_TOP      = (1 << DLY_CFG_W) - 1;

    // indexes past the register file; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_B = 3'd7;

    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = 16'sh8000;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [PAIR_W-1:0]       s_tdata = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [PAIR_W-1:0]       m_tdata;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

    int  fail_count;
    int  outstanding;
    int  holdoff_asked = 0;
    bit  rx_free = 1'b0;
    int  quiet_cycles = 0;

    always #5 aclk = ~aclk;

    stereo_chorus_delay dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    scd_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Output side: random ready/stall runs, free-running stretches, and a long
    // hold-off whenever the stimulus asks for one.
    initial begin : rx_pattern
        int run_len;
        bit run_ready;
        int served;
        run_len = 0;
        run_ready = 1'b1;
        served = 0;
        forever begin
            @(negedge aclk);
            if (served != holdoff_asked) begin
                served = holdoff_asked;
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES - 1) @(negedge aclk);
                run_len = 0;
            end else begin
                if (run_len == 0) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: begin
                            run_ready = 1'b1;
                            run_len = $urandom_range(1, 20);
                        end
                        6, 7, 8: begin
                            run_ready = 1'b0;
                            run_len = $urandom_range(1, 6);
                        end
                        default: begin
                            run_ready = 1'b0;
                            run_len = $urandom_range(7, 30);
                        end
                    endcase
                end
                m_tready <= run_ready || rx_free;
                run_len--;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] l,
                             input logic signed [SAMPLE_BITS-1:0] r);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {r, l};
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
    endtask

    task automatic pause_sender(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
    endtask

    // Drop valid and hold until every result is back.
    task automatic drain;
        pause_sender(1);
        wait (outstanding == 0);
        repeat (2) @(posedge aclk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return SMP_MAX;
                    1: return SMP_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            1, 2: return $urandom_range(0, 512) - 256;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_setting(input logic [CFG_IDX_W-1:0] idx);
        int k;
        k = $urandom_range(0, 7);
        case (idx)
            REG_PHASE_STEP: begin
                if (k == 0) return '0;
                if (k == 1) return (1 << STEP_W) - 1;
                return $urandom_range(0, (1 << STEP_W) - 1);
            end
            REG_MOD_DEPTH, REG_MIN_DELAY: begin
                if (k == 0) return '0;
                if (k == 1) return DELAY_TOP;
                if (k == 2) return $urandom_range(0, DELAY_TOP);
                // mostly delays short enough to read back recent input
                return $urandom_range(0, 96 << FRAC_W);
            end
            REG_WET_GAIN, REG_DRY_GAIN: begin
                if (k == 0) return '0;
                if (k == 1) return 1 << GAIN_SHIFT;
                if (k == 2) return $urandom_range(0, (1 << GAIN_W) - 1);
                return $urandom_range(0, 1 << GAIN_SHIFT);
            end
            REG_FEEDBACK_GAIN: begin
                if (k == 0) return 19'h0_8000;
                if (k == 1) return 19'h0_7FFF;
                return $urandom_range(0, (1 << GAIN_W) - 1);
            end
            default: return $urandom_range(0, DELAY_TOP);
        endcase
    endfunction

    task automatic stream_pairs(input int count, input int max_gap);
        int burst;
        burst = $urandom_range(1, 40);
        repeat (count) begin
            if (burst == 0) begin
                if (max_gap > 0) pause_sender($urandom_range(1, max_gap));
                burst = $urandom_range(1, 40);
            end
            send_pair(pick_sample(), pick_sample());
            burst--;
        end
    endtask

    initial begin : stimulus
        int sent;
        int phase_len;
        int max_gap;
        int phase_no;
        sent = 0;
        phase_no = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings, input extremes and alternating bit patterns
        send_pair(SMP_MAX, SMP_MIN);
        send_pair(SMP_MIN, SMP_MAX);
        send_pair('0, '0);
        send_pair('1, 16'sd1);
        send_pair(16'sh5555, 16'shAAAA);
        send_pair(16'shAAAA, 16'sh5555);
        send_pair(SMP_MAX, SMP_MAX);
        send_pair(SMP_MIN, SMP_MIN);
        drain();

        // zero delay, gains above unity, full positive feedback, frozen phase
        write_reg(REG_WET_GAIN, 19'h0_FFFF);
        write_reg(REG_DRY_GAIN, 19'h0_FFFF);
        write_reg(REG_FEEDBACK_GAIN, 19'h0_7FFF);
        write_reg(REG_MOD_DEPTH, '0);
        write_reg(REG_MIN_DELAY, '0);
        write_reg(REG_PHASE_STEP, '0);
        write_reg(REG_UNMAPPED_A, $urandom_range(0, DELAY_TOP));
        write_reg(REG_UNMAPPED_B, $urandom_range(0, DELAY_TOP));
        send_pair(SMP_MAX, SMP_MIN);
        send_pair(SMP_MIN, SMP_MAX);
        send_pair(16'sd12345, -16'sd12345);
        send_pair(SMP_MAX, SMP_MIN);
        send_pair(16'sd1, -16'sd1);
        drain();

        // delay saturated at the ring length, fastest phase, full negative feedback
        write_reg(REG_FEEDBACK_GAIN, 19'h0_8000);
        write_reg(REG_WET_GAIN, '0);
        write_reg(REG_DRY_GAIN, 1 << GAIN_SHIFT);
        write_reg(REG_MIN_DELAY, DELAY_TOP);
        write_reg(REG_MOD_DEPTH, DELAY_TOP);
        write_reg(REG_PHASE_STEP, (1 << STEP_W) - 1);
        send_pair(SMP_MAX, SMP_MIN);
        send_pair(SMP_MIN, SMP_MAX);
        send_pair(16'sh5555, 16'shAAAA);
        send_pair(SMP_MAX, SMP_MAX);
        send_pair(SMP_MIN, SMP_MIN);
        send_pair('1, '0);
        drain();

        // offset just below the ring end so the swing crosses the clamp
        write_reg(REG_MIN_DELAY, (2047 << FRAC_W) + 128);
        write_reg(REG_MOD_DEPTH, 200);
        write_reg(REG_WET_GAIN, 1 << GAIN_SHIFT);
        write_reg(REG_PHASE_STEP, 40000);
        send_pair(16'sd20000, -16'sd20000);
        send_pair(-16'sd300, 16'sd300);
        send_pair(SMP_MAX, SMP_MIN);
        send_pair(16'sd7, -16'sd7);
        send_pair(SMP_MIN, SMP_MAX);
        send_pair('0, '0);

        while (sent < ITEM_TARGET) begin
            drain();
            for (int r = REG_PHASE_STEP; r <= REG_FEEDBACK_GAIN; r++) begin
                if ($urandom_range(0, 1) == 1)
                    write_reg(CFG_IDX_W'(r), pick_setting(CFG_IDX_W'(r)));
            end
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_UNMAPPED_B, $urandom_range(0, DELAY_TOP));
            phase_len = $urandom_range(60, 200);
            rx_free = ($urandom_range(0, 4) == 0);
            max_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (phase_no == 2) begin
                // stall the output for a long stretch while input keeps coming
                rx_free = 1'b0;
                max_gap = 0;
                holdoff_asked++;
            end
            stream_pairs(phase_len, max_gap);
            sent += phase_len;
            phase_no++;
        end

        drain();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/scd_pkg.sv
hw/rtl/scd_delay_line.sv
hw/rtl/stereo_chorus_delay.sv
test/scd_checker.sv
test/tb.sv
